>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define TTHSC_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TTHSC_ASSERT_ALWAYS(lbl, ck, prop, msg) \
	lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> rtl/core/tthsc_pkg.sv
// Types, constants and the CRC step of the TTA1 header/seek table checker.
// No dependencies.
`default_nettype none
package tthsc_pkg;

	localparam int HDR_LEN    = 22;
	localparam int CRC_END    = 18;
	localparam int POS_W      = 25;
	localparam int ENT_W      = 24;
	localparam int SUM_W      = 55;
	localparam int FL_W       = 48;
	localparam int DIV_W      = 32;
	localparam int DVS_W      = 21;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
	// rate*256/245 == (rate*FRAME_RECIP) >> FRAME_SHIFT for any 20-bit rate
	localparam logic [28:0] FRAME_RECIP = 29'd280487661;
	localparam int FRAME_SHIFT = 28;
	localparam logic [FL_W-1:0] MIN_FILE_LEN = 48'd30;

	typedef enum logic [3:0] {
		ST_OK      = 4'd0,
		ST_SHORT   = 4'd1,
		ST_MAGIC   = 4'd2,
		ST_FIELD   = 4'd3,
		ST_MISM    = 4'd4,
		ST_HCRC    = 4'd5,
		ST_FRAMES  = 4'd6,
		ST_TABLE   = 4'd7,
		ST_ENTRY   = 4'd8,
		ST_TCRC    = 4'd9,
		ST_END     = 4'd10,
		ST_TRUNC   = 4'd11
	} status_t;

	typedef enum logic [1:0] {
		REG_RATE  = 2'd0,
		REG_CHAN  = 2'd1,
		REG_BITS  = 2'd2,
		REG_FLEN  = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_DIV_FL,
		BK_DIV_CNT,
		BK_CHECK
	} bk_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       eof;
	} item_t;

	typedef struct packed {
		logic [19:0]     exp_rate;
		logic [4:0]      exp_ch;
		logic [4:0]      exp_bits;
		logic [FL_W-1:0] file_len;
	} cfg_t;

	typedef struct packed {
		logic dividing;
		logic pop;
	} back_stat_t;

	// Reflected CRC-32, one byte.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tthsc_front.sv
// Front end: takes byte items and queues them for the back end.
// Depends on tthsc_pkg.
`default_nettype none
module tthsc_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  [7:0]          data_byte,
	input  wire                 first_byte,
	input  wire                 end_of_file,
	output logic                q_valid,
	output tthsc_pkg::item_t    q_item,
	input  wire                 pop
);
	import tthsc_pkg::*;

	item_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_q, rd_q;
	logic [FIFO_AW:0]    cnt_q;
	logic                push;
	item_t               in_item;

	assign in_ready = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign push     = in_valid & in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];

	always_comb begin
		in_item.data  = data_byte;
		in_item.first = first_byte;
		in_item.eof   = end_of_file;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

endmodule
`default_nettype wire

>>> rtl/core/tthsc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tthsc_pkg.
`default_nettype none
module tthsc_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [tthsc_pkg::DIV_W-1:0]       dividend,
	input  wire  [tthsc_pkg::DVS_W-1:0]       divisor,
	output logic                              busy,
	output logic                              done,
	output logic [tthsc_pkg::DIV_W-1:0]       quot,
	output logic [tthsc_pkg::DVS_W-1:0]       rem
);
	import tthsc_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  dvd_q, quot_q;
	logic [DVS_W-1:0]  dvs_q, rem_q;
	logic [DVS_W:0]    trial, diff;
	logic              ge;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DIV_W-1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W-1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			dvd_q  <= {dvd_q[DIV_W-2:0], 1'b0};
			quot_q <= {quot_q[DIV_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/tthsc_back.sv
// Back end: header capture and checks, seek table walk, verdict register.
// Depends on tthsc_pkg and tthsc_div.
`default_nettype none
module tthsc_back #(
	parameter logic [23:0] MAX_SEEK_ENTRIES = 24'd4000000,
	parameter logic [15:0] MAX_CHANNELS     = 16'd16,
	parameter logic [31:0] MAX_RATE         = 32'd1000000
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  tthsc_pkg::cfg_t            cfg,
	input  wire                        q_valid,
	input  tthsc_pkg::item_t           q_item,
	output logic                       pop,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic [3:0]                 status,
	output logic [31:0]                sample_total,
	output logic [21:0]                seek_entries,
	output logic [54:0]                audio_stop,
	output tthsc_pkg::back_stat_t      stat
);
	import tthsc_pkg::*;

	bk_state_t           state_q, state_n;
	logic [POS_W-1:0]    pos_q, pos_e, pos_n;
	logic [31:0]         crc_q, crc_e, crc_n;
	logic [31:0]         ea_q, ea_e, ea_n;
	logic [ENT_W-1:0]    rd_q, rd_e, rd_n;
	logic [ENT_W-1:0]    exp_q, exp_e, exp_n;
	logic [SUM_W-1:0]    sum_q, sum_e, sum_n;
	logic                verdict_q, verdict_e, verdict_n;
	logic                eof_q, eof_n;
	logic [DIV_W:0]      total_q, total_n;
	logic [7:0]          hdr_q [HDR_LEN];
	logic [7:0]          hv [HDR_LEN];
	logic                hdr_we;
	logic                hdr_pass;
	logic                out_free;
	logic                vld;
	status_t             code;
	logic [SUM_W-1:0]    ae;
	logic                div_start, div_busy, div_done;
	logic [DIV_W-1:0]    div_dvd, div_quot;
	logic [DVS_W-1:0]    div_dvs, div_rem;
	logic [15:0]         f_fmt, f_ch, f_bits;
	logic [31:0]         f_rate, f_count, f_stored, cnt_now;
	logic [19:0]         hdr_rate;
	logic [48:0]         fl_prod;
	logic [DVS_W-1:0]    frame_len;
	logic [26:0]         tbl_end;
	logic [FL_W:0]       tbl_need;
	logic                ov_q;
	logic [3:0]          st_q;
	logic [31:0]         sc_q;
	logic [21:0]         se_q;
	logic [54:0]         ae_q;

	assign out_free  = !ov_q || out_ready;
	assign pop       = (state_q == BK_RUN) && q_valid && out_free;
	assign stat.pop  = pop;
	assign stat.dividing = (state_q == BK_DIV_FL) || (state_q == BK_DIV_CNT) || div_busy;

	// Header as it stands once the current byte lands in the last slot.
	always_comb begin
		for (int i = 0; i < HDR_LEN - 1; i++) hv[i] = hdr_q[i+1];
		hv[HDR_LEN-1] = q_item.data;
	end
	assign f_fmt    = {hv[5], hv[4]};
	assign f_ch     = {hv[7], hv[6]};
	assign f_bits   = {hv[9], hv[8]};
	assign f_rate   = {hv[13], hv[12], hv[11], hv[10]};
	assign f_count  = {hv[17], hv[16], hv[15], hv[14]};
	assign f_stored = {hv[21], hv[20], hv[19], hv[18]};
	assign cnt_now  = {hdr_q[17], hdr_q[16], hdr_q[15], hdr_q[14]};

	// Frame length from the stored header; rate passed the limit check, so 20 bits.
	assign hdr_rate  = {hdr_q[12][3:0], hdr_q[11], hdr_q[10]};
	assign fl_prod   = 49'(hdr_rate) * 49'(FRAME_RECIP);
	assign frame_len = fl_prod[FRAME_SHIFT +: DVS_W];

	assign tbl_end  = 27'd26 + {1'b0, exp_e, 2'b00};
	assign tbl_need = {15'd0, total_q[31:0], 2'b00} + (FL_W+1)'(26);

	tthsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_RUN:     if (hdr_pass) state_n = BK_DIV_FL;
			BK_DIV_FL:  state_n = BK_DIV_CNT;
			BK_DIV_CNT: if (div_done) state_n = BK_CHECK;
			BK_CHECK:   if (out_free) state_n = BK_RUN;
			default:    state_n = BK_RUN;
		endcase
	end

	// Datapath and verdict.
	always_comb begin
		pos_e     = q_item.first ? '0 : pos_q;
		crc_e     = q_item.first ? ALL_ONES : crc_q;
		ea_e      = q_item.first ? '0 : ea_q;
		rd_e      = q_item.first ? '0 : rd_q;
		exp_e     = q_item.first ? '0 : exp_q;
		sum_e     = q_item.first ? '0 : sum_q;
		verdict_e = q_item.first ? 1'b0 : verdict_q;
		pos_n     = pos_q;
		crc_n     = crc_q;
		ea_n      = ea_q;
		rd_n      = rd_q;
		exp_n     = exp_q;
		sum_n     = sum_q;
		verdict_n = verdict_q;
		eof_n     = eof_q;
		total_n   = total_q;
		hdr_we    = 1'b0;
		hdr_pass  = 1'b0;
		vld       = 1'b0;
		code      = ST_OK;
		ae        = '0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			BK_RUN: begin
				if (pop) begin
					pos_n     = pos_e;
					crc_n     = crc_e;
					ea_n      = ea_e;
					rd_n      = rd_e;
					exp_n     = exp_e;
					sum_n     = sum_e;
					verdict_n = verdict_e;
					if (!verdict_e) begin
						pos_n = pos_e + 1'b1;
						if (pos_e == '0 && cfg.file_len < MIN_FILE_LEN) begin
							vld = 1'b1; code = ST_SHORT;
						end else if (pos_e < POS_W'(HDR_LEN)) begin
							hdr_we = 1'b1;
							if (pos_e < POS_W'(CRC_END)) crc_n = crc_byte(crc_e, q_item.data);
							if (pos_e == POS_W'(HDR_LEN-1)) begin
								if (hv[0] != 8'h54 || hv[1] != 8'h54 || hv[2] != 8'h41
									|| hv[3] != 8'h31) begin
									vld = 1'b1; code = ST_MAGIC;
								end else if (f_fmt != 16'd1 || f_ch == '0
									|| f_ch > MAX_CHANNELS
									|| !(f_bits == 16'd8 || f_bits == 16'd16 || f_bits == 16'd24)
									|| f_rate == '0 || f_rate > MAX_RATE || f_count == '0) begin
									vld = 1'b1; code = ST_FIELD;
								end else if (f_rate != {12'd0, cfg.exp_rate}
									|| f_ch != {11'd0, cfg.exp_ch}
									|| (cfg.exp_bits != '0 && f_bits != {11'd0, cfg.exp_bits}))
								begin
									vld = 1'b1; code = ST_MISM;
								end else if ((crc_e ^ ALL_ONES) != f_stored) begin
									vld = 1'b1; code = ST_HCRC;
								end else begin
									// frame length and entry count follow
									hdr_pass = 1'b1;
									eof_n    = q_item.eof;
								end
							end
						end else begin
							ea_n = {q_item.data, ea_e[31:8]};
							if (rd_e < exp_e) crc_n = crc_byte(crc_e, q_item.data);
							// last byte of a 4-byte word
							if (pos_e[1:0] == 2'b01) begin
								if (rd_e < exp_e) begin
									if (ea_n < 32'd4) begin
										vld = 1'b1; code = ST_ENTRY;
									end else begin
										sum_n = sum_e + SUM_W'(ea_n);
										rd_n  = rd_e + 1'b1;
									end
								end else if ((crc_e ^ ALL_ONES) != ea_n) begin
									vld = 1'b1; code = ST_TCRC;
								end else begin
									ae   = SUM_W'(tbl_end) + sum_e;
									vld  = 1'b1;
									code = (ae > SUM_W'(cfg.file_len)) ? ST_END : ST_OK;
								end
							end
						end
						if (!vld && !hdr_pass && q_item.eof) begin
							vld = 1'b1; code = ST_TRUNC;
						end
					end
				end
			end
			BK_DIV_FL: begin
				div_start = 1'b1;
				div_dvd   = cnt_now;
				div_dvs   = frame_len;
			end
			BK_DIV_CNT: begin
				if (div_done) total_n = {1'b0, div_quot} + {32'd0, (div_rem != '0)};
			end
			BK_CHECK: begin
				if (out_free) begin
					if (total_q > (DIV_W+1)'(MAX_SEEK_ENTRIES)) begin
						vld = 1'b1; code = ST_FRAMES;
					end else begin
						exp_n = total_q[ENT_W-1:0];
						if (tbl_need > (FL_W+1)'(cfg.file_len)) begin
							vld = 1'b1; code = ST_TABLE;
						end else begin
							crc_n = ALL_ONES;
							if (eof_q) begin
								vld = 1'b1; code = ST_TRUNC;
							end
						end
					end
				end
			end
			default: ;
		endcase
		if (vld) verdict_n = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_RUN;
			pos_q     <= '0;
			crc_q     <= ALL_ONES;
			ea_q      <= '0;
			rd_q      <= '0;
			exp_q     <= '0;
			sum_q     <= '0;
			verdict_q <= 1'b0;
			eof_q     <= 1'b0;
			total_q   <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q   <= state_n;
			pos_q     <= pos_n;
			crc_q     <= crc_n;
			ea_q      <= ea_n;
			rd_q      <= rd_n;
			exp_q     <= exp_n;
			sum_q     <= sum_n;
			verdict_q <= verdict_n;
			eof_q     <= eof_n;
			total_q   <= total_n;
			if (vld) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_we) begin
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] <= hv[i];
		end
		if (vld) begin
			st_q <= code;
			sc_q <= (code == ST_OK) ? cnt_now : '0;
			se_q <= exp_n[21:0];
			ae_q <= ae;
		end
	end

	assign out_valid    = ov_q;
	assign status       = st_q;
	assign sample_total = sc_q;
	assign seek_entries = se_q;
	assign audio_stop   = ae_q;

endmodule
`default_nettype wire

>>> rtl/core/tta_header_seek_table_check.sv
// Top level of the TTA1 header and seek table checker: config registers,
// front queue and back end. Depends on tthsc_pkg, tthsc_front, tthsc_back.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-----------------------------------------
//   in       | in_valid/in_ready  | data_byte, first_byte, end_of_file
//   out      | out_valid/out_ready| status, sample_total, seek_entries,
//            |                    | audio_stop
//   config   | APB psel/penable   | paddr, pwdata, prdata (64-bit regs)
//
// One byte item per cycle through the back end when no divide or verdict
// wait holds it off; one verdict per file. At the header end the next byte
// is held off for the frame length (reciprocal multiply), the 32 divide
// steps of the seek entry count, and the bound check.
// A 4-entry queue keeps taking bytes while the back end divides or the
// verdict register waits. Reset clears all control state; no clearing pass.
`default_nettype none
module tta_header_seek_table_check #(
	parameter logic [23:0] MAX_SEEK_ENTRIES = 24'd4000000,
	parameter logic [15:0] MAX_CHANNELS     = 16'd16,
	parameter logic [31:0] MAX_RATE         = 32'd1000000
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  data_byte,
	input  wire         first_byte,
	input  wire         end_of_file,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [3:0]  status,
	output logic [31:0] sample_total,
	output logic [21:0] seek_entries,
	output logic [54:0] audio_stop,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import tthsc_pkg::*;

	`include "assert_macros.svh"

	cfg_t        cfg_q;
	logic        cfg_we;
	reg_idx_t    reg_idx;
	logic        q_valid, pop;
	item_t       q_item;
	back_stat_t  bstat;
	logic        ok_out, stop_in_file, no_stop_out;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exp_rate <= 20'd44100;
			cfg_q.exp_ch   <= 5'd2;
			cfg_q.exp_bits <= 5'd0;
			cfg_q.file_len <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx)
				REG_RATE: cfg_q.exp_rate <= pwdata[19:0];
				REG_CHAN: cfg_q.exp_ch   <= pwdata[4:0];
				REG_BITS: cfg_q.exp_bits <= pwdata[4:0];
				REG_FLEN: cfg_q.file_len <= pwdata[FL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RATE: prdata = {44'd0, cfg_q.exp_rate};
			REG_CHAN: prdata = {59'd0, cfg_q.exp_ch};
			REG_BITS: prdata = {59'd0, cfg_q.exp_bits};
			REG_FLEN: prdata = {16'd0, cfg_q.file_len};
			default:  prdata = '0;
		endcase
	end

	// Byte queue: absorbs input while the back end is dividing.
	tthsc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.first_byte  (first_byte),
		.end_of_file (end_of_file),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.pop         (pop)
	);

	// Checks, divider and verdict register.
	tthsc_back #(
		.MAX_SEEK_ENTRIES (MAX_SEEK_ENTRIES),
		.MAX_CHANNELS     (MAX_CHANNELS),
		.MAX_RATE         (MAX_RATE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.sample_total (sample_total),
		.seek_entries (seek_entries),
		.audio_stop   (audio_stop),
		.stat         (bstat)
	);

	// Verdict classes for the checks below.
	assign ok_out       = out_valid && (status == ST_OK);
	assign stop_in_file = (audio_stop <= {7'd0, cfg_q.file_len});
	assign no_stop_out  = out_valid && (status != ST_OK) && (status != ST_END);

	`TTHSC_ASSERT_ALWAYS(a_no_pop_dividing, clk, bstat.dividing |-> !bstat.pop, "byte taken")
	`TTHSC_ASSERT(a_ok_inside_file, clk, arst_n, ok_out |-> stop_in_file, "ok past file end")
	`TTHSC_ASSERT(a_end_zero, clk, arst_n, no_stop_out |-> (audio_stop == '0), "audio stop set")

endmodule
`default_nettype wire
